// File: hdl/text_console_writer_unit_assert.svh
// Assertion macros for the text console writer.
// The clock is clk and the reset is arst_n in every module that uses them.
`ifndef TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define TCW_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define TCW_ASSERT_SAME(lbl, ante, cons, msg)
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: hdl/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

	// Field widths of the command and response beats
	localparam int KIND_W   = 2;
	localparam int CHAR_W   = 8;
	localparam int COLF_W   = 7;
	localparam int ROWF_W   = 5;
	localparam int CELL_W   = 16;
	localparam int COLOR_W  = 4;
	localparam int CFG_IDX_W = 1;

	localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
	localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0020;

	localparam logic [COLOR_W-1:0] FORE_RESET = 4'd15;
	localparam logic [COLOR_W-1:0] BACK_RESET = 4'd0;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUT   = 2'd0,
		KIND_SET   = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_READ  = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FORE_COLOR = 1'b0,
		REG_BACK_COLOR = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_RDWAIT,
		ST_SWEEP,
		ST_RESULT
	} state_t;

	typedef struct packed {
		kind_t              kind;
		logic [CHAR_W-1:0]  character;
		logic [COLF_W-1:0]  column;
		logic [ROWF_W-1:0]  row;
	} cmd_t;

	typedef struct packed {
		logic [COLF_W-1:0]  cursor_column;
		logic [ROWF_W-1:0]  cursor_row;
		logic               scrolled;
		logic [CELL_W-1:0]  cell_data;
	} rsp_t;

endpackage

`default_nettype wire

// File: hdl/tcw_cell_ram.sv
`default_nettype none

module tcw_cell_ram
	import tcw_pkg::*;
#(
	parameter int DEPTH = 2000,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic              re,
	input  wire logic [AW-1:0]     addr,
	input  wire logic [CELL_W-1:0] wdata,
	output logic      [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] mem [DEPTH];

	// Write or read one cell; read data is registered and shows in the next cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/text_console_writer_unit.sv
`default_nettype none

// Text console writer: a COLUMNS x ROWS grid of 16-bit text cells and a cursor.
// Command beats arrive on cmd (valid/ready): put character, set cursor, clear,
// read cell. Each command gives exactly one response beat on rsp (valid/ready)
// carrying the cursor after the command, a scroll flag and the cell data.
// Colors are set through the cfg write port (cfg_we, cfg_index, cfg_data); the
// user must set them only while no command is in flight, which the block does
// not enforce; writes take effect at once. Rows live in one single-port cell
// RAM as a ring: scrolling moves the top row pointer and blanks one row, so no
// rows are copied. A put or set cursor goes from EXEC to RESULT; a read waits
// in RDWAIT for the RAM data; a put that scrolls blanks a row in SWEEP, and a
// clear sweeps all cells. One command is in work at a time; the next is taken
// in the cycle after the response is loaded. The row blank and the clear sweep
// write one cell per cycle through the RAM write port.
// After reset the RAM is blanked by a sweep over all COLUMNS*ROWS cells during
// which cmd_ready stays low; cfg writes are taken throughout.
// A stalled rsp does not block acceptance of the next command; that command
// finishes and waits in the block until the pending response is taken.
module text_console_writer_unit
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cmd_valid,
	output logic                      cmd_ready,
	input  wire cmd_t                 cmd,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	output rsp_t                      rsp,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COLOR_W-1:0]   cfg_data
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int CW = $clog2(COLUMNS);
	localparam int RW = $clog2(ROWS);
	localparam int AW = $clog2(CELLS);
	localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);
	localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
	localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

	state_t state_q, state_d;

	logic [CW-1:0]     cur_col_q;
	logic [RW-1:0]     cur_row_q;
	logic [RW-1:0]     top_q;
	logic [AW-1:0]     sweep_addr_q;
	logic [AW-1:0]     sweep_end_q;
	logic [COLOR_W-1:0] fore_q;
	logic [COLOR_W-1:0] back_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;
	cmd_t              cmd_q;
	logic              res_scrolled_q;
	logic [CELL_W-1:0] res_data_q;

	logic              mem_we;
	logic              mem_re;
	logic [AW-1:0]     mem_addr;
	logic [CELL_W-1:0] mem_wdata;
	logic [CELL_W-1:0] mem_rdata;
	logic              rsp_load;

	logic              sweep_done;
	logic              is_newline;
	logic              adv_row;
	logic              scroll;
	logic [CW-1:0]     next_col;
	logic [RW-1:0]     next_row;
	logic [RW-1:0]     top_next;
	logic [CW-1:0]     in_col;
	logic [RW-1:0]     in_row;
	logic [CW-1:0]     sel_col;
	logic [RW-1:0]     sel_row;
	logic [RW:0]       ring_sum;
	logic [RW-1:0]     phys_row;
	logic [AW-1:0]     exec_addr;
	logic [AW-1:0]     top_base;
	logic [CELL_W-1:0] put_cell;

	tcw_cell_ram #(
		.DEPTH(CELLS)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.re   (mem_re),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// Saturate the command's column and row to the grid
	always_comb begin
		if ({1'b0, cmd_q.column} > (COLF_W + 1)'(COLUMNS - 1)) begin
			in_col = LAST_COL;
		end else begin
			in_col = CW'(cmd_q.column);
		end
		if (7'(cmd_q.row) > 7'(ROWS - 1)) begin
			in_row = LAST_ROW;
		end else begin
			in_row = RW'(cmd_q.row);
		end
	end

	// Map the logical row through the ring and form the cell address
	always_comb begin
		sel_col = (cmd_q.kind == KIND_READ) ? in_col : cur_col_q;
		sel_row = (cmd_q.kind == KIND_READ) ? in_row : cur_row_q;
		ring_sum = (RW + 1)'(sel_row) + (RW + 1)'(top_q);
		if (ring_sum >= (RW + 1)'(ROWS)) begin
			phys_row = RW'(ring_sum - (RW + 1)'(ROWS));
		end else begin
			phys_row = RW'(ring_sum);
		end
		exec_addr = AW'(phys_row) * COLS_A + AW'(sel_col);
		top_base = AW'(top_q) * COLS_A;
	end

	// Work out the cursor after a put
	always_comb begin
		is_newline = (cmd_q.character == NEWLINE_CHAR);
		adv_row = is_newline || (cur_col_q == LAST_COL);
		scroll = adv_row && (cur_row_q == LAST_ROW);
		next_col = adv_row ? '0 : CW'(cur_col_q + 1'b1);
		next_row = (adv_row && !scroll) ? RW'(cur_row_q + 1'b1) : cur_row_q;
		top_next = (top_q == LAST_ROW) ? '0 : RW'(top_q + 1'b1);
		put_cell = {back_q, fore_q, cmd_q.character};
		sweep_done = (sweep_addr_q == sweep_end_q);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (sweep_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (cmd_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (cmd_q.kind)
					KIND_PUT:   state_d = scroll ? ST_SWEEP : ST_RESULT;
					KIND_SET:   state_d = ST_RESULT;
					KIND_CLEAR: state_d = ST_SWEEP;
					KIND_READ:  state_d = ST_RDWAIT;
					default:    state_d = ST_RESULT;
				endcase
			end
			ST_RDWAIT: state_d = ST_RESULT;
			ST_SWEEP: begin
				if (sweep_done) state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (!rsp_valid_q || rsp_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	// State outputs: RAM port, handshakes
	always_comb begin
		cmd_ready = 1'b0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_addr = exec_addr;
		mem_wdata = put_cell;
		rsp_load = 1'b0;
		case (state_q)
			ST_INIT, ST_SWEEP: begin
				mem_we = 1'b1;
				mem_addr = sweep_addr_q;
				mem_wdata = BLANK_CELL;
			end
			ST_IDLE: cmd_ready = 1'b1;
			ST_EXEC: begin
				mem_we = (cmd_q.kind == KIND_PUT) && !is_newline;
				mem_re = (cmd_q.kind == KIND_READ);
			end
			ST_RESULT: rsp_load = !rsp_valid_q || rsp_ready;
			default: begin
				cmd_ready = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			cur_col_q <= '0;
			cur_row_q <= '0;
			top_q <= '0;
			sweep_addr_q <= '0;
			sweep_end_q <= AW'(CELLS - 1);
			fore_q <= FORE_RESET;
			back_q <= BACK_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// Take color writes at any time
			if (cfg_we) begin
				case (cfg_index)
					REG_FORE_COLOR: fore_q <= cfg_data;
					REG_BACK_COLOR: back_q <= cfg_data;
					default: begin
						fore_q <= fore_q;
					end
				endcase
			end

			// Advance the blanking sweep
			if ((state_q == ST_INIT || state_q == ST_SWEEP) && !sweep_done) begin
				sweep_addr_q <= sweep_addr_q + 1'b1;
			end

			// Apply the command
			if (state_q == ST_EXEC) begin
				case (cmd_q.kind)
					KIND_PUT: begin
						cur_col_q <= next_col;
						cur_row_q <= next_row;
						if (scroll) begin
							top_q <= top_next;
							sweep_addr_q <= top_base;
							sweep_end_q <= top_base + AW'(COLUMNS - 1);
						end
					end
					KIND_SET: begin
						cur_col_q <= in_col;
						cur_row_q <= in_row;
					end
					KIND_CLEAR: begin
						sweep_addr_q <= '0;
						sweep_end_q <= AW'(CELLS - 1);
					end
					default: begin
						cur_col_q <= cur_col_q;
					end
				endcase
			end

			// Hold the response until taken
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_EXEC) begin
			res_scrolled_q <= (cmd_q.kind == KIND_PUT) && scroll;
			res_data_q <= ((cmd_q.kind == KIND_PUT) && !is_newline) ? put_cell : '0;
		end
		if (state_q == ST_RDWAIT) begin
			res_data_q <= mem_rdata;
		end
		if (rsp_load) begin
			rsp_q.cursor_column <= COLF_W'(cur_col_q);
			rsp_q.cursor_row <= ROWF_W'(cur_row_q);
			rsp_q.scrolled <= res_scrolled_q;
			rsp_q.cell_data <= res_data_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

`include "text_console_writer_unit_assert.svh"

	`TCW_ASSERT_NEXT(a_accept_exec, cmd_valid && cmd_ready, state_q == ST_EXEC, "accepted beat not executed")
	`TCW_ASSERT_SAME(a_sweep_range, state_q == ST_INIT || state_q == ST_SWEEP, sweep_addr_q <= AW'(CELLS - 1) && sweep_addr_q <= sweep_end_q, "sweep address out of range")
	`TCW_ASSERT_SAME(a_scroll_cursor, rsp_valid && rsp.scrolled, rsp.cursor_row == ROWF_W'(ROWS - 1) && rsp.cursor_column == '0, "scroll response with cursor off the last row start")
	`TCW_ASSERT_SAME(a_grid_bounds, state_q != ST_INIT, top_q <= LAST_ROW && cur_row_q <= LAST_ROW && cur_col_q <= LAST_COL, "cursor or top row outside the grid")

endmodule

`default_nettype wire

// File: dv/tcw_console_checker.sv
module tcw_console_checker
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  logic                 cmd_ready,
	input  cmd_t                 cmd,
	input  logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  rsp_t                 rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COLOR_W-1:0]   cfg_data,
	output int                   mismatches,
	output int                   open_beats
);

	localparam int CELLS = COLUMNS * ROWS;

	// Shadow of the text grid, cursor and colors
	logic [CELL_W-1:0]  screen [CELLS];
	int                 cur_x;
	int                 cur_y;
	logic [COLOR_W-1:0] fg;
	logic [COLOR_W-1:0] bg;

	// Replies still owed by the block, oldest first
	rsp_t console_replies [$];

	function automatic void blank_screen();
		for (int i = 0; i < CELLS; i++)
			screen[i] = BLANK_CELL;
	endfunction

	// Apply one command to the shadow state and return the reply it should give
	function automatic rsp_t run_console_cmd(input cmd_t c);
		rsp_t r;
		int   x;
		int   y;
		r = '0;
		x = (int'(c.column) > COLUMNS - 1) ? COLUMNS - 1 : int'(c.column);
		y = (int'(c.row) > ROWS - 1) ? ROWS - 1 : int'(c.row);
		case (c.kind)
		KIND_PUT: begin
			if (c.character == NEWLINE_CHAR) begin
				cur_x = 0;
				cur_y++;
			end else begin
				r.cell_data = {bg, fg, c.character};
				screen[cur_y * COLUMNS + cur_x] = r.cell_data;
				cur_x++;
			end
			// wrap at the row end
			if (cur_x >= COLUMNS) begin
				cur_x = 0;
				cur_y++;
			end
			// past the last row: shift every row up and blank the bottom one
			if (cur_y >= ROWS) begin
				for (int i = 0; i < CELLS - COLUMNS; i++)
					screen[i] = screen[i + COLUMNS];
				for (int i = CELLS - COLUMNS; i < CELLS; i++)
					screen[i] = BLANK_CELL;
				cur_y = ROWS - 1;
				r.scrolled = 1'b1;
			end
		end
		KIND_SET: begin
			cur_x = x;
			cur_y = y;
		end
		KIND_CLEAR: begin
			blank_screen();
		end
		KIND_READ: begin
			r.cell_data = screen[y * COLUMNS + x];
		end
		endcase
		r.cursor_column = COLF_W'(cur_x);
		r.cursor_row = ROWF_W'(cur_y);
		return r;
	endfunction

	// Track config writes, check reply beats, predict on command beats
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			blank_screen();
			cur_x = 0;
			cur_y = 0;
			fg = FORE_RESET;
			bg = BACK_RESET;
			console_replies.delete();
			open_beats <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_FORE_COLOR)
					fg = cfg_data;
				else if (cfg_index == REG_BACK_COLOR)
					bg = cfg_data;
			end
			if (rsp_valid && rsp_ready) begin
				if (console_replies.size() == 0) begin
					if (mismatches < 10)
						$display("rsp beat with no command waiting: col %0d row %0d scr %0b cell %h",
							rsp.cursor_column, rsp.cursor_row, rsp.scrolled, rsp.cell_data);
					mismatches++;
				end else begin
					want = console_replies.pop_front();
					if (rsp.cursor_column !== want.cursor_column ||
						rsp.cursor_row !== want.cursor_row ||
						rsp.scrolled !== want.scrolled ||
						rsp.cell_data !== want.cell_data) begin
						if (mismatches < 10) begin
							$write("rsp beat differs: exp col %0d row %0d scr %0b cell %h,",
								want.cursor_column, want.cursor_row, want.scrolled,
								want.cell_data);
							$display(" got col %0d row %0d scr %0b cell %h",
								rsp.cursor_column, rsp.cursor_row, rsp.scrolled,
								rsp.cell_data);
						end
						mismatches++;
					end
				end
			end
			if (cmd_valid && cmd_ready)
				console_replies.push_back(run_console_cmd(cmd));
			open_beats <= console_replies.size();
		end
	end

endmodule

// File: dv/testbench.sv
module testbench;
	import tcw_pkg::*;

	localparam int COLUMNS = 80;
	localparam int ROWS = 25;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 400;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cmd_valid = 1'b0;
	logic                 cmd_ready;
	cmd_t                 cmd = '0;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b0;
	rsp_t                 rsp;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COLOR_W-1:0]   cfg_data = '0;

	int mismatches;
	int open_beats;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_requests = 0;
	int cycles = 0;

	always #1 clk = ~clk;

	text_console_writer_unit #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	tcw_console_checker #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.open_beats(open_beats)
	);

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("text_console_writer_unit: mismatch");
			$finish;
		end
	end

	// Reply side: random stalls, plus a long hold-off on request
	initial begin
		int hold_left;
		int holds_served;
		hold_left = 0;
		holds_served = 0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_served) begin
				holds_served = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				rsp_ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	function automatic cmd_t mk_cmd(kind_t k, logic [CHAR_W-1:0] ch,
		logic [COLF_W-1:0] col, logic [ROWF_W-1:0] r);
		cmd_t c;
		c.kind = k;
		c.character = ch;
		c.column = col;
		c.row = r;
		return c;
	endfunction

	// Drive one command beat and hold it until cmd_ready is seen high after an edge
	task automatic offer_cmd(input cmd_t c);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
	endtask

	// Drop valid and wait until every reply has come back
	task automatic wait_drained();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (open_beats != 0)
			@(posedge clk);
	endtask

	task automatic set_colors(input logic [COLOR_W-1:0] fore, input logic [COLOR_W-1:0] back);
		cfg_we <= 1'b1;
		cfg_index <= REG_FORE_COLOR;
		cfg_data <= fore;
		@(posedge clk);
		cfg_index <= REG_BACK_COLOR;
		cfg_data <= back;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly text with newlines, mixed with cursor moves, reads and rare clears
	task automatic run_random_phase(input int n);
		cmd_t c;
		int   pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			c.character = CHAR_W'($urandom_range(0, 255));
			c.column = COLF_W'($urandom_range(0, 127));
			c.row = ROWF_W'($urandom_range(0, 31));
			if (pick < 10) begin
				c.kind = KIND_PUT;
				c.character = NEWLINE_CHAR;
			end else if (pick < 72) begin
				c.kind = KIND_PUT;
			end else if (pick < 82) begin
				c.kind = KIND_SET;
			end else if (pick < 99) begin
				c.kind = KIND_READ;
			end else begin
				c.kind = KIND_CLEAR;
			end
			offer_cmd(c);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		tx_idle_pct = 29;
		rx_idle_pct = 51;
		set_colors(4'h0, 4'hF);

		// directed: field extremes, wrap, scroll, saturation, clear
		offer_cmd(mk_cmd(KIND_READ, 8'h00, 7'd0, 5'd0));
		offer_cmd(mk_cmd(KIND_PUT, 8'h00, 7'd0, 5'd0));
		offer_cmd(mk_cmd(KIND_PUT, 8'hFF, 7'd127, 5'd31));
		offer_cmd(mk_cmd(KIND_PUT, NEWLINE_CHAR, 7'd0, 5'd0));
		offer_cmd(mk_cmd(KIND_SET, 8'h00, 7'd127, 5'd31));
		offer_cmd(mk_cmd(KIND_PUT, 8'h41, 7'd0, 5'd0));
		offer_cmd(mk_cmd(KIND_READ, 8'hFF, 7'd127, 5'd31));
		offer_cmd(mk_cmd(KIND_READ, 8'h00, 7'd79, 5'd23));
		offer_cmd(mk_cmd(KIND_SET, 8'h00, 7'd79, 5'd0));
		offer_cmd(mk_cmd(KIND_PUT, 8'h42, 7'd0, 5'd0));
		offer_cmd(mk_cmd(KIND_SET, 8'h00, 7'd80, 5'd25));
		offer_cmd(mk_cmd(KIND_PUT, NEWLINE_CHAR, 7'd0, 5'd0));
		offer_cmd(mk_cmd(KIND_READ, 8'h00, 7'd80, 5'd25));
		offer_cmd(mk_cmd(KIND_SET, 8'h00, 7'd0, 5'd0));
		offer_cmd(mk_cmd(KIND_PUT, 8'h55, 7'd0, 5'd0));
		offer_cmd(mk_cmd(KIND_PUT, 8'hAA, 7'd0, 5'd0));
		offer_cmd(mk_cmd(KIND_CLEAR, 8'hFF, 7'd127, 5'd31));
		offer_cmd(mk_cmd(KIND_READ, 8'h00, 7'd1, 5'd0));
		offer_cmd(mk_cmd(KIND_READ, 8'h00, 7'd0, 5'd0));
		wait_drained();

		set_colors(4'hF, 4'hF);
		run_random_phase(130);
		wait_drained();

		tx_idle_pct = 51;
		rx_idle_pct = 29;
		set_colors(4'h0, 4'h0);
		run_random_phase(130);
		wait_drained();

		// no idling; stall the reply side long enough to back up the command side
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_colors(COLOR_W'($urandom_range(0, 15)), COLOR_W'($urandom_range(0, 15)));
		hold_requests++;
		run_random_phase(130);
		wait_drained();

		repeat (100) @(posedge clk);
		if (mismatches == 0 && open_beats == 0)
			$display("text_console_writer_unit: match");
		else
			$display("text_console_writer_unit: mismatch");
		$finish;
	end

endmodule

// File: files.f
+incdir+hdl
hdl/tcw_pkg.sv
hdl/tcw_cell_ram.sv
hdl/text_console_writer_unit.sv
dv/tcw_console_checker.sv
dv/testbench.sv
